@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	`ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	`ASSERT_CLK(lbl, clk, rst_n, (ante) |=> (cons))

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/sqlcws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlcws_pkg
// Shared types and character codes for the SQL comment/whitespace stripper.
// ----------------------------------------------------------------------------
package sqlcws_pkg;

	localparam logic [7:0] CH_SQUOTE   = 8'h27;
	localparam logic [7:0] CH_DQUOTE   = 8'h22;
	localparam logic [7:0] CH_BACKTICK = 8'h60;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_DASH     = 8'h2D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_NUL      = 8'h00;

	localparam int unsigned MAX_RES = 3;

	typedef enum logic [1:0] {
		ZONE_PLAIN  = 2'd0,
		ZONE_STRING = 2'd1,
		ZONE_BLOCK  = 2'd2,
		ZONE_LINE   = 2'd3
	} zone_t;

	// Results caused by one input beat; cnt is 1..3
	typedef struct packed {
		logic [1:0]               cnt;
		logic                     has;
		logic                     last;
		logic [MAX_RES-1:0][7:0]  bytes;
	} group_t;

	// Queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Front state flags, exposed for checking
	typedef struct packed {
		logic held;
		logic sp;
		logic seen;
	} front_stat_t;

endpackage

@@ hw/rtl/sqlcws_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlcws_front
// Accepts input beats, tracks the zone and builds each beat's result group.
// ----------------------------------------------------------------------------
module sqlcws_front import sqlcws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  q_stat_t     q_stat,
	output logic        push,
	output group_t      push_grp,
	output front_stat_t fstat
);

	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [1:0]              n;
		logic                    sp;
		logic                    seen;
	} acc_t;

	zone_t      zone_q, zone_d;
	logic [7:0] quote_q, quote_d;
	logic [7:0] prev_q;
	logic       held_q, held_d;
	logic       sp_q;
	logic       seen_q;
	logic       done;
	logic       accept;
	acc_t       acc;

	function automatic acc_t emit_kept(acc_t a, logic [7:0] b);
		acc_t r;
		r = a;
		if (b == CH_NUL) begin
			r.sp = 1'b1;
		end else begin
			if (r.sp && r.seen) begin
				r.bytes[r.n] = CH_SPACE;
				r.n = r.n + 2'd1;
			end
			r.sp = 1'b0;
			r.bytes[r.n] = b;
			r.n = r.n + 2'd1;
			r.seen = 1'b1;
		end
		return r;
	endfunction

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		acc      = '0;
		acc.sp   = sp_q;
		acc.seen = seen_q;
		zone_d   = zone_q;
		quote_d  = quote_q;
		held_d   = 1'b0;
		done     = 1'b0;

		// Resolve a held slash or dash first
		if (held_q) begin
			if (prev_q == CH_SLASH && in_byte == CH_STAR) begin
				zone_d = ZONE_BLOCK;
				acc.sp = 1'b1;
				done   = 1'b1;
			end else if (prev_q == CH_DASH && in_byte == CH_DASH) begin
				zone_d = ZONE_LINE;
				acc.sp = 1'b1;
				done   = 1'b1;
			end else begin
				acc = emit_kept(acc, prev_q);
			end
		end

		if (!done) begin
			unique case (zone_q)
				ZONE_STRING: begin
					if (in_byte == quote_q) begin
						zone_d  = ZONE_PLAIN;
						quote_d = CH_NUL;
					end
					acc = emit_kept(acc, in_byte);
				end
				ZONE_PLAIN: begin
					priority if (in_byte == CH_SQUOTE || in_byte == CH_DQUOTE ||
							in_byte == CH_BACKTICK) begin
						zone_d  = ZONE_STRING;
						quote_d = in_byte;
						acc     = emit_kept(acc, in_byte);
					end else if (prev_q == CH_SLASH && in_byte == CH_STAR) begin
						zone_d = ZONE_BLOCK;
						acc.sp = 1'b1;
					end else if (prev_q == CH_DASH && in_byte == CH_DASH) begin
						zone_d = ZONE_LINE;
						acc.sp = 1'b1;
					end else if (in_byte == CH_SPACE || in_byte == CH_TAB ||
							in_byte == CH_CR || in_byte == CH_LF ||
							in_byte == CH_NUL) begin
						acc.sp = 1'b1;
					end else if (in_byte == CH_SLASH || in_byte == CH_DASH) begin
						held_d = 1'b1;
					end else begin
						acc = emit_kept(acc, in_byte);
					end
				end
				ZONE_BLOCK: begin
					if (prev_q == CH_STAR && in_byte == CH_SLASH) begin
						zone_d = ZONE_PLAIN;
					end
					acc.sp = 1'b1;
				end
				ZONE_LINE: begin
					if (in_byte == CH_LF) begin
						zone_d = ZONE_PLAIN;
					end
					acc.sp = 1'b1;
				end
				default: begin
					acc.sp = 1'b1;
				end
			endcase
		end

		// End of query: release a held byte, drop a trailing separator
		if (in_last && held_d) begin
			held_d = 1'b0;
			acc    = emit_kept(acc, in_byte);
		end

		push_grp.bytes = acc.bytes;
		push_grp.has   = (acc.n != 2'd0);
		push_grp.cnt   = (acc.n == 2'd0) ? 2'd1 : acc.n;
		push_grp.last  = in_last;
		push           = accept && ((acc.n != 2'd0) || in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q  <= ZONE_PLAIN;
			quote_q <= CH_NUL;
			prev_q  <= CH_NUL;
			held_q  <= 1'b0;
			sp_q    <= 1'b0;
			seen_q  <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				zone_q  <= ZONE_PLAIN;
				quote_q <= CH_NUL;
				prev_q  <= CH_NUL;
				held_q  <= 1'b0;
				sp_q    <= 1'b0;
				seen_q  <= 1'b0;
			end else begin
				zone_q  <= zone_d;
				quote_q <= quote_d;
				prev_q  <= in_byte;
				held_q  <= held_d;
				sp_q    <= acc.sp;
				seen_q  <= acc.seen;
			end
		end
	end

	assign fstat.held = held_q;
	assign fstat.sp   = sp_q;
	assign fstat.seen = seen_q;

endmodule

@@ hw/rtl/sqlcws_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlcws_queue
// Short queue of result groups between the front and the back.
// ----------------------------------------------------------------------------
module sqlcws_queue import sqlcws_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  group_t  push_grp,
	input  logic    pop,
	output group_t  pop_grp,
	output q_stat_t q_stat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [PW-1:0] PTR_ONE  = PW'(1);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	group_t        mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign do_push = push && (cnt_q != FULL_CNT);
	assign do_pop  = pop && (cnt_q != '0);

	assign q_stat.full  = (cnt_q == FULL_CNT);
	assign q_stat.empty = (cnt_q == '0);
	assign pop_grp      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_ONE;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CNT_ONE;
				2'b01:   cnt_q <= cnt_q - CNT_ONE;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/sqlcws_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlcws_back
// Unpacks result groups and drives one result beat per cycle while not stalled.
// ----------------------------------------------------------------------------
module sqlcws_back import sqlcws_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_stat_t    q_stat,
	input  group_t     pop_grp,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       out_last
);

	group_t     grp_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       ov_q;
	logic [7:0] ob_q;
	logic       oh_q;
	logic       ol_q;
	logic       adv;
	logic       grp_end;

	// Advance when the output register is free or being drained
	assign adv     = busy_q && (!ov_q || !out_stall);
	assign grp_end = (idx_q == grp_q.cnt - 2'd1);
	assign pop     = !q_stat.empty && (!busy_q || (adv && grp_end));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (adv) begin
				if (grp_end) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (adv) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= pop_grp;
		end
		if (adv) begin
			ob_q <= grp_q.bytes[idx_q];
			oh_q <= grp_q.has;
			ol_q <= grp_q.last && grp_end;
		end
	end

	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign has_byte  = oh_q;
	assign out_last  = ol_q;

endmodule

@@ hw/rtl/sql_comment_whitespace_stripper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_comment_whitespace_stripper
// Removes SQL comments and collapses whitespace in a byte stream.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Beat payload
//  --------+-----------+--------------------+-------------------------------
//  in      | sink      | in_valid/in_stall  | in_byte, in_last
//  out     | source    | out_valid/out_stall| out_byte, has_byte, out_last
//
//  One input beat is taken per cycle while in_stall is low; each beat yields
//  zero to three result beats; the output side drives at most one per cycle.
//  Results pass through the group queue, group register and output register.
//  in_stall rises only when the group queue (QDEPTH entries) is full.
//  arst_n clears zone, held byte, separator flags, queue and output valid.
//
// The front classifies every byte against the current zone (plain, string,
// block comment, line comment) and the raw previous byte, and packs the
// results of one beat into a group. A slash or dash in plain text is held
// back one beat so that it can vanish if it opens a comment. Groups pass
// through a short queue; the back unpacks them, one result per cycle while
// not stalled, into an output register, so a stall on the output does not
// block the input until the queue fills. A query that ends with nothing to
// emit gives one empty end marker (has_byte low, out_last high).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sql_comment_whitespace_stripper import sqlcws_pkg::*; #(
	parameter int unsigned QDEPTH = 4 // group queue depth, 2 or more
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       out_last
);

	q_stat_t     q_stat;
	front_stat_t fstat;
	group_t      push_grp;
	group_t      pop_grp;
	logic        push;
	logic        pop;

	// Classify and build result groups
	sqlcws_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_stat   (q_stat),
		.push     (push),
		.push_grp (push_grp),
		.fstat    (fstat)
	);

	// Decouple front from back
	sqlcws_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.pop_grp  (pop_grp),
		.q_stat   (q_stat)
	);

	// Serialise groups onto the output channel
	sqlcws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_grp   (pop_grp),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.out_last  (out_last)
	);

	// An empty end marker only closes a query and carries a zero byte
	`ASSERT_IMPLY(a_marker_last, clk, arst_n, out_valid && !has_byte,
		out_last && (out_byte == CH_NUL))
	// A full queue always holds the input back
	`ASSERT_IMPLY(a_full_stalls, clk, arst_n, q_stat.full, in_stall)
	// The last beat of a query returns the front flags to their reset values
	`ASSERT_NEXT(a_query_reset, clk, arst_n, in_valid && !in_stall && in_last,
		!fstat.held && !fstat.sp && !fstat.seen)

endmodule

@@ bench/tb_sql_comment_whitespace_stripper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sql_comment_whitespace_stripper
// Self-checking bench for the SQL comment and whitespace stripper: queries
// go in one byte per beat, and every cleaned beat that comes out is checked
// against an in-bench prediction of the stripping rules.
// ----------------------------------------------------------------------------
module tb_sql_comment_whitespace_stripper;
	import sqlcws_pkg::*;

	localparam int WATCHDOG_CYCLES = 1000; // cycles with no beat on either side
	localparam int DRAIN_CYCLES    = 8;    // latency plus margin after the last result
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;

	// One cleaned output beat
	typedef struct packed {
		logic [7:0] chr;
		logic       has;
		logic       last;
	} clean_beat_t;

	typedef enum {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_mode_t;
	typedef enum {TOK_WORD, TOK_BLANK, TOK_STRING, TOK_BLOCK, TOK_LINE, TOK_OP} token_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       in_last   = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       out_last;

	sql_comment_whitespace_stripper uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.has_byte (has_byte),
		.out_last (out_last)
	);

	// Predicted stripper state, mirroring the block's
	zone_t       zone_q;
	logic [7:0]  quote_q;
	logic [7:0]  prev_q;
	logic        held_q;
	logic        sep_q;
	logic        seen_q;

	clean_beat_t pending_clean_q[$]; // cleaned beats still to come out
	clean_beat_t group_q[$];         // beats caused by the current input beat
	logic [7:0]  text_q[$];          // query text being built for sending

	int          errors      = 0;
	int          beats_sent  = 0;
	int          burst_left  = 0;
	int          gap_max     = 0;
	int          stall_tick  = 0;
	stall_mode_t stall_mode  = STALL_NONE;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic void clear_predictor();
		zone_q  = ZONE_PLAIN;
		quote_q = CH_NUL;
		prev_q  = CH_NUL;
		held_q  = 1'b0;
		sep_q   = 1'b0;
		seen_q  = 1'b0;
	endfunction

	// Emit a kept byte; a zero byte only marks a separator. A pending
	// separator turns into one space, but never before the first byte.
	function automatic void keep_byte(logic [7:0] b);
		if (b == CH_NUL) begin
			sep_q = 1'b1;
		end else begin
			if (sep_q && seen_q)
				group_q.push_back('{CH_SPACE, 1'b1, 1'b0});
			sep_q = 1'b0;
			group_q.push_back('{b, 1'b1, 1'b0});
			seen_q = 1'b1;
		end
	endfunction

	function automatic void predict_clean(logic [7:0] c, logic fin);
		logic [7:0] prv;
		logic       opened;
		prv    = prev_q;
		opened = 1'b0;
		group_q.delete();

		// Resolve a held slash or dash first: it either opens a comment or
		// goes out as an ordinary byte.
		if (held_q) begin
			held_q = 1'b0;
			if (prv == CH_SLASH && c == CH_STAR) begin
				zone_q = ZONE_BLOCK;
				sep_q  = 1'b1;
				opened = 1'b1;
			end else if (prv == CH_DASH && c == CH_DASH) begin
				zone_q = ZONE_LINE;
				sep_q  = 1'b1;
				opened = 1'b1;
			end else begin
				keep_byte(prv);
			end
		end

		if (!opened) begin
			case (zone_q)
				ZONE_STRING: begin
					if (c == quote_q) begin
						zone_q  = ZONE_PLAIN;
						quote_q = CH_NUL;
					end
					keep_byte(c);
				end
				ZONE_PLAIN: begin
					if (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BACKTICK) begin
						zone_q  = ZONE_STRING;
						quote_q = c;
						keep_byte(c);
					end else if (prv == CH_SLASH && c == CH_STAR) begin
						// the previous byte is raw: it may have closed a comment
						zone_q = ZONE_BLOCK;
						sep_q  = 1'b1;
					end else if (prv == CH_DASH && c == CH_DASH) begin
						zone_q = ZONE_LINE;
						sep_q  = 1'b1;
					end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF
							|| c == CH_NUL) begin
						sep_q = 1'b1;
					end else if (c == CH_SLASH || c == CH_DASH) begin
						held_q = 1'b1;
					end else begin
						keep_byte(c);
					end
				end
				ZONE_BLOCK: begin
					if (prv == CH_STAR && c == CH_SLASH)
						zone_q = ZONE_PLAIN;
					sep_q = 1'b1;
				end
				default: begin
					if (c == CH_LF)
						zone_q = ZONE_PLAIN;
					sep_q = 1'b1;
				end
			endcase
		end
		prev_q = c;

		// End of query: release a held byte, drop a trailing separator, mark
		// the last beat (an empty marker if nothing came out) and start afresh.
		if (fin) begin
			if (held_q) begin
				held_q = 1'b0;
				keep_byte(c);
			end
			if (group_q.size() == 0)
				group_q.push_back('{CH_NUL, 1'b0, 1'b0});
			group_q[group_q.size() - 1].last = 1'b1;
			clear_predictor();
		end
		foreach (group_q[i])
			pending_clean_q.push_back(group_q[i]);
	endfunction

	// ------------------------------------------------------------------
	// Sender: bursts of random length, random gaps between them
	// ------------------------------------------------------------------
	task automatic send_beat(input logic [7:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= fin;
		// hold the beat until the block takes it
		do @(posedge clk); while (in_stall);
		predict_clean(b, fin);
		beats_sent++;
	endtask

	// Send the built text as one query, last flag on its final byte
	task automatic send_text();
		foreach (text_q[i])
			send_beat(text_q[i], i == text_q.size() - 1);
	endtask

	// Drop valid and hold off until every predicted beat has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_clean_q.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Query text generation
	// ------------------------------------------------------------------
	function automatic void push_str(string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	// Mostly arbitrary non-zero bytes, often one of the characters the
	// stripper reacts to
	function automatic logic [7:0] rand_text_byte();
		logic [7:0] marks [10];
		marks = '{CH_SQUOTE, CH_DQUOTE, CH_BACKTICK, CH_SLASH, CH_STAR,
			CH_DASH, CH_LF, CH_CR, CH_TAB, CH_SPACE};
		if ($urandom_range(0, 3) == 0)
			return marks[$urandom_range(0, 9)];
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic void add_token(token_t tok);
		int         len;
		logic [7:0] q;
		len = $urandom_range(0, 6);
		case (tok)
			TOK_WORD: begin
				repeat (len + 1) text_q.push_back(8'($urandom_range(CH_LOW_A, CH_LOW_Z)));
			end
			TOK_BLANK: begin
				repeat (len / 2 + 1) begin
					case ($urandom_range(0, 3))
						0:       text_q.push_back(CH_SPACE);
						1:       text_q.push_back(CH_TAB);
						2:       text_q.push_back(CH_CR);
						default: text_q.push_back(CH_LF);
					endcase
				end
			end
			TOK_STRING: begin
				case ($urandom_range(0, 2))
					0:       q = CH_SQUOTE;
					1:       q = CH_DQUOTE;
					default: q = CH_BACKTICK;
				endcase
				text_q.push_back(q);
				repeat (len) text_q.push_back(rand_text_byte());
				if ($urandom_range(0, 9) != 0)
					text_q.push_back(q);
			end
			TOK_BLOCK: begin
				text_q.push_back(CH_SLASH);
				text_q.push_back(CH_STAR);
				repeat (len) text_q.push_back(rand_text_byte());
				if ($urandom_range(0, 9) != 0) begin
					text_q.push_back(CH_STAR);
					text_q.push_back(CH_SLASH);
				end
			end
			TOK_LINE: begin
				text_q.push_back(CH_DASH);
				text_q.push_back(CH_DASH);
				repeat (len) text_q.push_back(rand_text_byte());
				if ($urandom_range(0, 9) != 0)
					text_q.push_back(CH_LF);
			end
			default: begin
				case ($urandom_range(0, 3))
					0:       text_q.push_back(CH_SLASH);
					1:       text_q.push_back(CH_DASH);
					2:       text_q.push_back(CH_STAR);
					default: text_q.push_back(CH_EQUAL);
				endcase
			end
		endcase
	endfunction

	// A well-formed-ish query of a few tokens; one in eight is raw noise
	function automatic void build_query();
		text_q.delete();
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(1, 7)) add_token(token_t'($urandom_range(0, 5)));
		end
	endfunction

	// ------------------------------------------------------------------
	// Receiver stall pattern
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		case (stall_mode)
			STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
			STALL_BURSTY: out_stall <= ((stall_tick % 8) < 3);
			default:      out_stall <= 1'b0;
		endcase
	end

	// ------------------------------------------------------------------
	// Result checker: compare each output beat with the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		clean_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_clean_q.size() == 0) begin
				$error("unexpected beat: out_byte %h has_byte %b out_last %b",
					out_byte, has_byte, out_last);
				errors++;
			end else begin
				want = pending_clean_q.pop_front();
				if (out_byte !== want.chr) begin
					$error("out_byte: expected %h, got %h", want.chr, out_byte);
					errors++;
				end
				if (has_byte !== want.has) begin
					$error("has_byte: expected %b, got %b", want.has, has_byte);
					errors++;
				end
				if (out_last !== want.last) begin
					$error("out_last: expected %b, got %b", want.last, out_last);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if nothing moves for too long
	// ------------------------------------------------------------------
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("FAIL sql_comment_whitespace_stripper");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Directed corner cases, sent back to back with no stalls
	task automatic test_edge_cases();
		stall_mode = STALL_NONE;
		gap_max    = 0;
		// lone dash: held back, then released at the end of the query
		text_q.delete(); push_str("-"); send_text();
		// block comment still open at the end: only the empty end marker
		text_q.delete(); push_str("/*"); send_text();
		// leading separators and zero byte dropped, trailing tab gives the marker
		text_q.delete();
		text_q.push_back(CH_SPACE); text_q.push_back(CH_NUL);
		push_str("a"); text_q.push_back(CH_TAB);
		send_text();
		// zero byte inside a string becomes a single space
		text_q.delete();
		text_q.push_back(CH_SQUOTE); text_q.push_back(CH_NUL); push_str("b");
		send_text();
		// line comment collapses to one space
		text_q.delete(); push_str("a--q"); text_q.push_back(CH_LF); push_str("b"); send_text();
		// empty block comment between two words
		text_q.delete(); push_str("c/**/d"); send_text();
		// unterminated backtick string carrying the byte extremes
		text_q.delete();
		text_q.push_back(CH_BACKTICK); text_q.push_back(8'hFF); text_q.push_back(8'h01);
		send_text();
		// lone double quote, string opened on the last byte
		text_q.delete(); text_q.push_back(CH_DQUOTE); send_text();
	endtask

	// Random queries of words, blanks, strings and comments
	task automatic test_comment_mix(input int beats);
		int stop_at;
		stop_at    = beats_sent + beats;
		stall_mode = STALL_RANDOM;
		gap_max    = 5;
		while (beats_sent < stop_at) begin
			build_query();
			send_text();
		end
	endtask

	// Unstructured non-zero bytes, queries of random length
	task automatic test_raw_bytes(input int beats);
		int stop_at;
		stop_at    = beats_sent + beats;
		stall_mode = STALL_BURSTY;
		gap_max    = 2;
		while (beats_sent < stop_at) begin
			text_q.delete();
			repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(1, 255)));
			send_text();
		end
	endtask

	// Full-rate input against a stalling receiver, with a pause to drain
	task automatic test_back_pressure(input int beats);
		int stop_at;
		stall_mode = STALL_BURSTY;
		gap_max    = 0;
		stop_at    = beats_sent + beats / 2;
		while (beats_sent < stop_at) begin
			build_query();
			send_text();
		end
		wait_drained();
		stall_mode = STALL_RANDOM;
		stop_at    = beats_sent + beats / 2;
		while (beats_sent < stop_at) begin
			build_query();
			send_text();
		end
	endtask

	initial begin
		clear_predictor();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_cases();
		test_comment_mix(250);
		test_raw_bytes(90);
		test_back_pressure(70);

		// Let everything drain, then allow for the pipeline latency
		in_valid   <= 1'b0;
		stall_mode = STALL_NONE;
		while (pending_clean_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("PASS sql_comment_whitespace_stripper");
		else
			$display("FAIL sql_comment_whitespace_stripper");
		$finish;
	end

endmodule

@@ sql_comment_whitespace_stripper.f @@
+incdir+hw/rtl
hw/rtl/sqlcws_pkg.sv
hw/rtl/sqlcws_front.sv
hw/rtl/sqlcws_queue.sv
hw/rtl/sqlcws_back.sv
hw/rtl/sql_comment_whitespace_stripper.sv
bench/tb_sql_comment_whitespace_stripper.sv
